>>> sv/dspm_pkg.sv
// shared types for the distance signature point match block
`timescale 1ns / 1ps
`default_nettype none
package dspm_pkg;
   localparam int COORD_BITS = 12;

   localparam logic [1:0] CMD_LOAD_SAMPLE = 2'd0;
   localparam logic [1:0] CMD_LOAD_GROUND = 2'd1;
   localparam logic [1:0] CMD_RUN         = 2'd2;

   typedef struct packed {
      logic [1:0]            command;
      logic [COORD_BITS-1:0] x_coord;
      logic [COORD_BITS-1:0] y_coord;
   } req_type;

   typedef struct packed {
      logic [5:0] best_ground;
      logic [5:0] best_sample;
      logic [5:0] best_count;
   } rsp_type;
endpackage
`default_nettype wire

>>> sv/dspm_ram.sv
// generic ram with one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module dspm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

>>> sv/distance_signature_point_match.sv
// top level of the distance signature point match block
//
//  channel | ports          | handshake
//  req     | req_payload    | start high and busy low
//  rsp     | rsp_payload    | rsp_valid one cycle, no back pressure
//
// a load does not raise busy; a new item may follow the next cycle.
// a run reads both point rams through a sequencer: for each (k, j, i) it
// scans all ground points g one at a time (address, then compare), through
// the single read port of the ground ram. reset returns to idle and clears
// the point counts and rsp_valid, not the rams.
`timescale 1ns / 1ps
`default_nettype none
module distance_signature_point_match #(
   parameter int MAX_SAMPLE_POINTS = 64,
   parameter int MAX_GROUND_POINTS = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire dspm_pkg::req_type  req_payload,
   output logic                    rsp_valid,
   output dspm_pkg::rsp_type       rsp_payload
);
   localparam int COORD_BITS = dspm_pkg::COORD_BITS;
   localparam int SA = (MAX_SAMPLE_POINTS > 1) ? $clog2(MAX_SAMPLE_POINTS) : 1;
   localparam int GA = (MAX_GROUND_POINTS > 1) ? $clog2(MAX_GROUND_POINTS) : 1;
   localparam int SC = $clog2(MAX_SAMPLE_POINTS + 1);
   localparam int GC = $clog2(MAX_GROUND_POINTS + 1);
   localparam int DB = 2 * COORD_BITS + 1;
   localparam int PW = 2 * COORD_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_RDK, S_RDI, S_RDJ, S_WJ, S_SCAN, S_WG, S_CMP, S_NEXT, S_DONE
   } state_type;

   state_type       state_ff;
   logic [SC-1:0]   scnt_ff;
   logic [GC-1:0]   gcnt_ff;
   logic [SA-1:0]   k_ff, i_ff, bk_ff;
   logic [GA-1:0]   j_ff, g_ff, bj_ff;
   logic [SC-1:0]   c_ff, bc_ff;
   logic [COORD_BITS-1:0] kx_ff, ky_ff, jx_ff, jy_ff;
   logic [DB-1:0]   d_ff;
   logic            hit_ff;

   // ram ports
   logic                    s_we, g_we;
   logic [SA-1:0]           s_ra;
   logic [GA-1:0]           g_ra;
   logic [PW-1:0]           s_rd, g_rd, wdata;
   logic                    acc;

   assign acc   = start && !busy;
   assign wdata = {req_payload.x_coord, req_payload.y_coord};
   assign s_we  = acc && req_payload.command == dspm_pkg::CMD_LOAD_SAMPLE
                  && scnt_ff < SC'(MAX_SAMPLE_POINTS);
   assign g_we  = acc && req_payload.command == dspm_pkg::CMD_LOAD_GROUND
                  && gcnt_ff < GC'(MAX_GROUND_POINTS);
   assign busy  = state_ff != S_IDLE;

   dspm_ram #(.WIDTH(PW), .DEPTH(1 << SA)) u_sram (
      .clock, .wr_en(s_we), .wr_addr(scnt_ff[SA-1:0]), .wr_data(wdata),
      .rd_addr(s_ra), .rd_data(s_rd));
   dspm_ram #(.WIDTH(PW), .DEPTH(1 << GA)) u_gram (
      .clock, .wr_en(g_we), .wr_addr(gcnt_ff[GA-1:0]), .wr_data(wdata),
      .rd_addr(g_ra), .rd_data(g_rd));

   // read addresses follow the sequencer
   always_comb begin
      s_ra = (state_ff == S_RDK) ? k_ff : i_ff;
      g_ra = (state_ff == S_RDJ) ? j_ff : g_ff;
   end

   // squared distance of two points
   function automatic logic [DB-1:0] sqd(input logic [COORD_BITS-1:0] ax, ay, bx, by);
      logic [COORD_BITS-1:0] dx, dy;
      dx = (ax > bx) ? ax - bx : bx - ax;
      dy = (ay > by) ? ay - by : by - ay;
      return DB'(PW'(dx) * PW'(dx)) + DB'(PW'(dy) * PW'(dy));
   endfunction

   // sequencer: k outer, j middle, i inner, g scan over ground set
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         scnt_ff   <= '0;
         gcnt_ff   <= '0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (s_we) scnt_ff <= scnt_ff + 1'b1;
               if (g_we) gcnt_ff <= gcnt_ff + 1'b1;
               if (acc && req_payload.command == dspm_pkg::CMD_RUN) begin
                  k_ff <= '0; bc_ff <= '0; bk_ff <= '0; bj_ff <= '0;
                  state_ff <= (scnt_ff >= SC'(2) && gcnt_ff != '0) ? S_RDK : S_DONE;
               end
            end
            S_RDK: begin
               j_ff <= '0;
               state_ff <= S_RDJ;
            end
            S_RDJ: begin
               if (j_ff == '0) begin
                  kx_ff <= s_rd[PW-1:COORD_BITS];
                  ky_ff <= s_rd[COORD_BITS-1:0];
               end
               state_ff <= S_WJ;
            end
            S_WJ: begin
               jx_ff <= g_rd[PW-1:COORD_BITS];
               jy_ff <= g_rd[COORD_BITS-1:0];
               i_ff <= k_ff + 1'b1;
               c_ff <= '0;
               state_ff <= S_RDI;
            end
            S_RDI: begin
               g_ff <= '0;
               hit_ff <= 1'b0;
               state_ff <= S_CMP;
            end
            S_CMP: begin
               // sample distance for i, ready after ram read
               d_ff <= sqd(kx_ff, ky_ff, s_rd[PW-1:COORD_BITS], s_rd[COORD_BITS-1:0]);
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               // ground address g_ff is read this cycle
               state_ff <= S_WG;
            end
            S_WG: begin
               if (sqd(jx_ff, jy_ff, g_rd[PW-1:COORD_BITS], g_rd[COORD_BITS-1:0]) == d_ff)
                  hit_ff <= 1'b1;
               if (GC'(g_ff) + 1'b1 < gcnt_ff) begin
                  g_ff <= g_ff + 1'b1;
                  state_ff <= S_SCAN;
               end else begin
                  state_ff <= S_NEXT;
               end
            end
            S_NEXT: begin
               // close out i, then j, then k
               if (SC'(i_ff) + 1'b1 < scnt_ff) begin
                  c_ff <= c_ff + SC'(hit_ff);
                  i_ff <= i_ff + 1'b1;
                  state_ff <= S_RDI;
               end else begin
                  if (c_ff + SC'(hit_ff) > bc_ff) begin
                     bc_ff <= c_ff + SC'(hit_ff);
                     bk_ff <= k_ff;
                     bj_ff <= j_ff;
                  end
                  if (GC'(j_ff) + 1'b1 < gcnt_ff) begin
                     j_ff <= j_ff + 1'b1;
                     state_ff <= S_RDJ;
                  end else if (SC'(k_ff) + SC'(2) < scnt_ff) begin
                     k_ff <= k_ff + 1'b1;
                     state_ff <= S_RDK;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end
            end
            S_DONE: begin
               rsp_valid <= 1'b1;
               rsp_payload.best_ground <= 6'(bj_ff);
               rsp_payload.best_sample <= 6'(bk_ff);
               rsp_payload.best_count  <= (bc_ff > SC'(63)) ? 6'd63 : 6'(bc_ff);
               scnt_ff <= '0;
               gcnt_ff <= '0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire
